[design/tet_pkg.sv]
// ----------------------------------------------------------------------------
// tet_pkg
// Shared sizes, codes and helpers of the token expiry table.
// ----------------------------------------------------------------------------
package tet_pkg;

   localparam int ENTRIES     = 128;
   localparam int KEY_BITS    = 32;
   localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_BITS   = $clog2(ENTRIES + 1);
   localparam int SAT_BITS    = (FILL_BITS > 8) ? FILL_BITS : 8;
   localparam int EXP_BITS    = 32;
   localparam int ENTRY_BITS  = KEY_BITS + EXP_BITS;
   localparam int COUNT_MAX   = 255;

   localparam logic [1:0] OP_GENERATE = 2'd0;
   localparam logic [1:0] OP_RENEW    = 2'd1;
   localparam logic [1:0] OP_COUNT    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   function automatic logic [KEY_BITS-1:0] key_of(input logic [31:0] k);
      logic [63:0]         w;
      logic [KEY_BITS-1:0] r;
      w = {32'b0, k};
      for (int i = 0; i < KEY_BITS; i++) begin
         r[i] = w[i];
      end
      return r;
   endfunction

endpackage

[design/tet_if.sv]
// ----------------------------------------------------------------------------
// tet_if
// Valid/ready channels of the token expiry table: request, response, csr.
// ----------------------------------------------------------------------------
interface tet_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] token_key;
   logic [30:0] now;
   modport source (output valid, op, token_key, now, input ready);
   modport sink   (input valid, op, token_key, now, output ready);
endinterface

interface tet_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] live_count;
   modport source (output valid, live_count, input ready);
   modport sink   (input valid, live_count, output ready);
endinterface

interface tet_csr_if;
   logic        valid;
   logic        ready;
   logic [30:0] time_to_live;
   modport source (output valid, time_to_live, input ready);
   modport sink   (input valid, time_to_live, output ready);
endinterface

[design/token_expiry_table.sv]
// ----------------------------------------------------------------------------
// token_expiry_table
// Table of keys with an expiry time; generate appends, renew refreshes the
// first live match, count reports the live entries.
// ----------------------------------------------------------------------------
//   channel  direction  payload                     transfer
//   req_bus  in         op, token_key, now          valid & ready
//   rsp_bus  out        live_count (count only)     valid & ready
//   csr_bus  in         time_to_live                valid & ready
//
// Generate writes its entry when it is taken. Renew and count step through the
// entry RAM, one read per cycle, and hold the request side from the transfer
// until the scan ends; renew ends early on a match, count then loads the output
// register in a finish state.
// A count result sits in an output register; a new request is taken while it
// waits, and a later count holds until that slot is free.
// Reset clears fill level, state and time_to_live (to 1); the RAM is not
// cleared, only entries below the fill level are read.
// ----------------------------------------------------------------------------
module token_expiry_table
   import tet_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tet_req_if.sink   req_bus,
   tet_rsp_if.source rsp_bus,
   tet_csr_if.sink   csr_bus
);

   state_type             state_ff, state_in;
   logic [30:0]           ttl_ff;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [FILL_BITS-1:0]  issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [IDX_BITS-1:0]   pend_idx_ff, pend_idx_in;
   logic [FILL_BITS-1:0]  cnt_ff, cnt_in;
   logic [1:0]            op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [30:0]           now_ff;
   logic [EXP_BITS-1:0]   exp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic [EXP_BITS-1:0]   req_exp;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [ENTRY_BITS-1:0] rd_data;
   logic [KEY_BITS-1:0]   rd_key;
   logic [EXP_BITS-1:0]   rd_exp;
   logic                  live;
   logic [SAT_BITS-1:0]   cnt_wide;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_exp       = {1'b0, req_bus.now} + {1'b0, ttl_ff};

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.live_count = rsp_count_ff;

   assign rd_key   = rd_data[ENTRY_BITS-1:EXP_BITS];
   assign rd_exp   = rd_data[EXP_BITS-1:0];
   assign live     = rd_exp > {1'b0, now_ff};
   assign cnt_wide = SAT_BITS'(cnt_ff);
   assign rd_en    = (state_ff == ST_SCAN) && (issue_ff < fill_ff);

   tet_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_idx_in  = issue_ff[IDX_BITS-1:0];
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[IDX_BITS-1:0];
      wr_data      = {key_of(req_bus.token_key), req_exp};

      unique case (state_ff)
         ST_IDLE: begin
            issue_in = '0;
            cnt_in   = '0;
            if (accept) begin
               case (req_bus.op) inside
                  OP_GENERATE: begin
                     if (fill_ff < FILL_BITS'(ENTRIES)) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  OP_RENEW, OP_COUNT: state_in = ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            pend_in = rd_en;
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            if (pend_ff) begin
               if (live) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (op_ff == OP_RENEW && live && rd_key == key_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = pend_idx_ff;
                  wr_data  = {key_ff, exp_ff};
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end else if (!rd_en) begin
               state_in = (op_ff == OP_COUNT) ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = (cnt_wide > SAT_BITS'(COUNT_MAX)) ?
                              8'(COUNT_MAX) : cnt_wide[7:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ttl_ff       <= 31'd1;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            ttl_ff <= csr_bus.time_to_live;
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      pend_idx_ff  <= pend_idx_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
      if (accept) begin
         op_ff  <= req_bus.op;
         key_ff <= key_of(req_bus.token_key);
         now_ff <= req_bus.now;
         exp_ff <= req_exp;
      end
   end

endmodule

[design/tet_ram.sv]
// ----------------------------------------------------------------------------
// tet_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
